// ===== design/multichannel_boxcar_averager_core_macros.svh =====
// Assertion macros shared by the boxcar averager modules.
// Depends on nothing; included by the files that check their own logic.
`ifndef MULTICHANNEL_BOXCAR_AVERAGER_CORE_MACROS_SVH
`define MULTICHANNEL_BOXCAR_AVERAGER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Check at each rising edge, skipped while reset is high.
`define MBA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("boxcar averager assertion failed");
// Check at each rising edge, reset cycles included.
`define MBA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("boxcar averager reset assertion failed");
`else
`define MBA_ASSERT(lbl, clk, rst, prop)
`define MBA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== design/mba_pkg.sv =====
// Package for the boxcar averager: sizes, operation codes and the
// controller/datapath command and status types. Depends on nothing.
package mba_pkg;

  localparam int WINDOW_LEN   = 16;
  localparam int SUM_SHIFT    = 4;
  localparam int CHANNELS     = 3;
  localparam int FRAME_FIELDS = 3;
  localparam int SAMPLE_W     = 12;
  localparam int CHAN_W       = 2;
  localparam int IDX_W        = $clog2(WINDOW_LEN);
  localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_LEN);
  localparam int AVG_MAX      = 4095;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef sample_t [CHANNELS-1:0] row_t;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    sample_t             motor_temp_sample;
    sample_t             amp_temp_a_sample;
    sample_t             amp_temp_b_sample;
    logic [CHAN_W-1:0]   query_channel;
  } frame_t;

  typedef struct packed {
    logic store_we;
    logic start;
    logic rd_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic addr_last;
    logic out_busy;
  } stat_t;

endpackage

// ===== design/mba_req_if.sv =====
// Input channel of the boxcar averager: handshake plus one request item.
// Depends on mba_pkg for field widths.
interface mba_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  mba_pkg::sample_t           motor_temp_sample;
  mba_pkg::sample_t           amp_temp_a_sample;
  mba_pkg::sample_t           amp_temp_b_sample;
  logic [mba_pkg::CHAN_W-1:0] query_channel;

  modport source (
    output valid, operation, motor_temp_sample, amp_temp_a_sample,
           amp_temp_b_sample, query_channel,
    input  ready
  );
  modport sink (
    input  valid, operation, motor_temp_sample, amp_temp_a_sample,
           amp_temp_b_sample, query_channel,
    output ready
  );
endinterface

// ===== design/mba_rsp_if.sv =====
// Output channel of the boxcar averager: handshake plus one average.
// Depends on mba_pkg for the field width.
interface mba_rsp_if;
  logic             valid;
  logic             ready;
  mba_pkg::sample_t average;

  modport source (output valid, average, input ready);
  modport sink (input valid, average, output ready);
endinterface

// ===== design/mba_ctrl.sv =====
// Sequencer of the boxcar averager: accepts requests and steps the window sweep.
// Depends on mba_pkg for the command and status types.
module mba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_operation,
  output logic           req_ready,
  input  mba_pkg::stat_t stat,
  output mba_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SUM    = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   req_xfer;

  assign req_ready = (state == ST_IDLE) && !rst;
  assign req_xfer  = req_valid && req_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_xfer) begin
          if (req_operation == mba_pkg::OP_QUERY) begin
            cmd.start  = 1'b1;
            state_next = ST_SUM;
          end else begin
            cmd.store_we = 1'b1;
          end
        end
      end
      ST_SUM: begin
        cmd.rd_en = 1'b1;
        if (stat.addr_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // hold the result until the output register is free
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

// ===== design/mba_datapath.sv =====
// Datapath of the boxcar averager: sample ring memory, write index, sweep
// counter, accumulator and output register. Depends on mba_pkg and the macros.
`include "multichannel_boxcar_averager_core_macros.svh"

module mba_datapath (
  input  logic            clk,
  input  logic            rst,
  input  mba_pkg::frame_t frame,
  input  mba_pkg::cmd_t   cmd,
  output mba_pkg::stat_t  stat,
  mba_rsp_if.source       rsp
);

  mba_pkg::row_t                   mem [mba_pkg::WINDOW_LEN];
  logic [mba_pkg::WINDOW_LEN-1:0]  row_valid;
  logic [mba_pkg::IDX_W-1:0]       wr_idx;
  logic [mba_pkg::IDX_W-1:0]       rd_addr;
  mba_pkg::row_t                   rd_row;
  logic                            rd_ok;
  logic                            rd_vld;
  logic [mba_pkg::CHAN_W-1:0]      chan_q;
  logic [mba_pkg::SUM_W-1:0]       acc;
  logic                            out_valid;
  mba_pkg::sample_t                avg_q;

  mba_pkg::row_t                   wr_row;
  mba_pkg::sample_t                frame_fields [mba_pkg::FRAME_FIELDS];
  mba_pkg::sample_t                lane;
  logic                            chan_ok;
  logic [mba_pkg::SUM_W-1:0]       shifted;
  mba_pkg::sample_t                avg_next;

  assign frame_fields[0] = frame.motor_temp_sample;
  assign frame_fields[1] = frame.amp_temp_a_sample;
  assign frame_fields[2] = frame.amp_temp_b_sample;

  // channels without a frame field are written zero, which is their reset value
  for (genvar c = 0; c < mba_pkg::CHANNELS; c++) begin : g_lane
    if (c < mba_pkg::FRAME_FIELDS) begin : g_field
      assign wr_row[c] = frame_fields[c];
    end else begin : g_zero
      assign wr_row[c] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_we) mem[wr_idx] <= wr_row;
    if (cmd.rd_en)    rd_row <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      wr_idx    <= '0;
      rd_addr   <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
      if (cmd.store_we) begin
        row_valid[wr_idx] <= 1'b1;
        if (wr_idx == mba_pkg::IDX_W'(mba_pkg::WINDOW_LEN - 1)) wr_idx <= '0;
        else                                                   wr_idx <= wr_idx + 1'b1;
      end
      if (cmd.start) begin
        rd_addr <= '0;
      end else if (cmd.rd_en) begin
        if (stat.addr_last) rd_addr <= '0;
        else                rd_addr <= rd_addr + 1'b1;
      end
      if (cmd.load_out)            out_valid <= 1'b1;
      else if (out_valid && rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_ok <= row_valid[rd_addr];
    if (cmd.start) chan_q <= frame.query_channel;
    if (cmd.start)      acc <= '0;
    else if (rd_vld)    acc <= acc + mba_pkg::SUM_W'(lane);
    if (cmd.load_out)   avg_q <= avg_next;
  end

  assign chan_ok = int'(chan_q) < mba_pkg::CHANNELS;

  always_comb begin
    lane = '0;
    for (int c = 0; c < mba_pkg::CHANNELS; c++) begin
      if (int'(chan_q) == c) lane = rd_row[c];
    end
    if (!rd_ok) lane = '0;
  end

  always_comb begin
    shifted = acc >> mba_pkg::SUM_SHIFT;
    if (!chan_ok)
      avg_next = '0;
    else if (shifted > mba_pkg::SUM_W'(mba_pkg::AVG_MAX))
      avg_next = mba_pkg::SAMPLE_W'(mba_pkg::AVG_MAX);
    else
      avg_next = shifted[mba_pkg::SAMPLE_W-1:0];
  end

  assign stat.addr_last = rd_addr == mba_pkg::IDX_W'(mba_pkg::WINDOW_LEN - 1);
  assign stat.out_busy  = out_valid && !rsp.ready;

  assign rsp.valid   = out_valid;
  assign rsp.average = avg_q;

  `MBA_ASSERT(a_no_result_overwrite, clk, rst, cmd.load_out |-> !(out_valid && !rsp.ready))
  `MBA_ASSERT(a_no_store_in_sweep, clk, rst, cmd.store_we |-> !cmd.rd_en && !rd_vld)
  `MBA_ASSERT(a_sweep_ends, clk, rst, cmd.rd_en && stat.addr_last |=> rd_vld && !cmd.rd_en)
  `MBA_ASSERT_ALWAYS(a_reset_clears, clk, $past(rst) |-> row_valid == '0 && !out_valid)

endmodule

// ===== design/multichannel_boxcar_averager_core.sv =====
// Boxcar averager core: a store frame is written at its transfer and the next request may follow at once.
// A query sweeps the WINDOW_LEN rows of the sample memory, one row per cycle through its single
// read port, then waits in ST_FINISH until the output register is free and loads its average there;
// the next request is taken only after that, so a query is never overlapped by another request.
// Synchronous reset zeroes the write index, empties the output register and clears one valid
// bit per memory row; rows never written read as zero. No clearing pass is run.
module multichannel_boxcar_averager_core (
  input  logic      clk,
  input  logic      rst,
  mba_req_if.sink   req,
  mba_rsp_if.source rsp
);

  // Command and status between the sequencer and the datapath.
  mba_pkg::cmd_t   cmd;
  mba_pkg::stat_t  stat;
  mba_pkg::frame_t frame;
  logic            req_ready;

  // Pack the request payload; the datapath samples it only on the transfer cycle.
  assign frame.motor_temp_sample = req.motor_temp_sample;
  assign frame.amp_temp_a_sample = req.amp_temp_a_sample;
  assign frame.amp_temp_b_sample = req.amp_temp_b_sample;
  assign frame.query_channel     = req.query_channel;

  // Ready is high only while the sequencer idles: a store completes in its transfer
  // cycle, a query holds the channel until its average is in the output register.
  assign req.ready = req_ready;

  mba_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req.valid),
    .req_operation (req.operation),
    .req_ready     (req_ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // The datapath owns the output register, so a finished average waits there
  // while the next request is taken.
  mba_datapath u_datapath (
    .clk   (clk),
    .rst   (rst),
    .frame (frame),
    .cmd   (cmd),
    .stat  (stat),
    .rsp   (rsp)
  );

endmodule

// ===== tb/sv/tb_multichannel_boxcar_averager_core.sv =====
// Self-checking testbench for multichannel_boxcar_averager_core: drives store and query
// transfers, predicts each window average, and checks every result in order.
// Depends on mba_pkg, mba_req_if, mba_rsp_if and the core itself.
`timescale 1ns / 100ps

module tb_multichannel_boxcar_averager_core;
  import mba_pkg::*;

  // Generous bound; the slowest legal run is far below it.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 750;
  localparam int MAX_IDLE = 17;

  // Keeps its own copy of the sample rings and the write position, and holds
  // the averages still owed by the block, oldest first.
  class window_average_board;
    sample_t ring [CHANNELS][WINDOW_LEN];
    int      wr_pos;
    sample_t pending_averages [$];
    int      mismatches;
    int      stores;
    int      queries;
    int      checked;

    function new();
      foreach (ring[c, k]) ring[c][k] = '0;
      wr_pos = 0;
      mismatches = 0;
      stores = 0;
      queries = 0;
      checked = 0;
    endfunction

    // Update the rings for a store, or queue the expected average for a query.
    function void note_request(op_t op, sample_t s0, sample_t s1, sample_t s2,
                               logic [CHAN_W-1:0] chan);
      sample_t frame [FRAME_FIELDS];
      int      sum;
      int      avg;
      frame[0] = s0;
      frame[1] = s1;
      frame[2] = s2;
      if (op == OP_STORE) begin
        for (int c = 0; c < FRAME_FIELDS && c < CHANNELS; c++) ring[c][wr_pos] = frame[c];
        wr_pos = (wr_pos == WINDOW_LEN - 1) ? 0 : wr_pos + 1;
        stores++;
      end else begin
        avg = 0;
        if (int'(chan) < CHANNELS) begin
          sum = 0;
          for (int k = 0; k < WINDOW_LEN; k++) sum += int'(ring[chan][k]);
          avg = sum >> SUM_SHIFT;
          if (avg > AVG_MAX) avg = AVG_MAX;
        end
        pending_averages.push_back(sample_t'(avg));
        queries++;
      end
    endfunction

    // Compare one returned average with the oldest one owed.
    function void check_average(sample_t actual);
      sample_t want;
      if (pending_averages.size() == 0) begin
        $display("%0t: unexpected average, expected none, actual %0d", $time, actual);
        mismatches++;
      end else begin
        want = pending_averages.pop_front();
        checked++;
        if (actual !== want) begin
          $display("%0t: average mismatch, expected %0d, actual %0d", $time, want, actual);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;
  // When set, both sides run back to back with no idle cycles.
  bit   calm;

  window_average_board board;

  mba_req_if req_ch ();
  mba_rsp_if rsp_ch ();

  multichannel_boxcar_averager_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // 2 ns clock: low for 1 ns, then high for 1 ns.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: end the run if the block stops making progress.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Draw an idle count for one transfer on either side.
  function automatic int draw_idle();
    return calm ? 0 : int'($urandom_range(0, MAX_IDLE));
  endfunction

  // Skew samples toward the extremes now and then so both ends of the range
  // show up often; the high bias packs the window with near-full-scale values.
  function automatic sample_t pick_sample(bit high_bias);
    int pick;
    pick = $urandom_range(0, 7);
    if (high_bias) return sample_t'($urandom_range(3800, 4095));
    if (pick == 0) return '0;
    if (pick == 1) return sample_t'(AVG_MAX);
    return sample_t'($urandom_range(0, 4095));
  endfunction

  // Offer one request and hold it until the block takes it. Called at a falling
  // edge; returns at the falling edge after the transfer with valid still high,
  // so a back-to-back request just replaces the payload.
  task automatic send_request(op_t op, sample_t s0, sample_t s1, sample_t s2,
                              logic [CHAN_W-1:0] chan);
    int gap;
    bit taken;
    gap = draw_idle();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid             <= 1'b1;
    req_ch.operation         <= op;
    req_ch.motor_temp_sample <= s0;
    req_ch.amp_temp_a_sample <= s1;
    req_ch.amp_temp_b_sample <= s2;
    req_ch.query_channel     <= chan;
    do begin
      @(posedge clk);
      taken = req_ch.ready;
      if (taken) board.note_request(op, s0, s1, s2, chan);
      @(negedge clk);
    end while (!taken);
  endtask

  // Store with random query_channel, which the block must ignore.
  task automatic send_store(sample_t s0, sample_t s1, sample_t s2);
    send_request(OP_STORE, s0, s1, s2, CHAN_W'($urandom_range(0, 3)));
  endtask

  // Query with random sample fields, which the block must ignore.
  task automatic send_query(logic [CHAN_W-1:0] chan);
    send_request(OP_QUERY, sample_t'($urandom), sample_t'($urandom), sample_t'($urandom),
                 chan);
  endtask

  // Result side: stall for a random count, then hold ready until an average
  // transfers. Sample at the rising edge, drive at the falling edge.
  initial begin
    int stall;
    bit got;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do begin
        @(posedge clk);
        got = (rsp_ch.valid === 1'b1);
        if (got) board.check_average(rsp_ch.average);
        @(negedge clk);
      end while (!got);
    end
  end

  // Stimulus and end of run.
  initial begin
    bit high_bias;
    op_t op;
    board = new();
    calm = 1'b0;
    high_bias = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_STORE;
    req_ch.motor_temp_sample = '0;
    req_ch.amp_temp_a_sample = '0;
    req_ch.amp_temp_b_sample = '0;
    req_ch.query_channel = '0;

    // Hold reset high from the start, then release it at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: the cleared store must average to zero on every channel, and
    // the absent fourth channel answers zero.
    for (int c = 0; c < 4; c++) send_query(CHAN_W'(c));
    // Fill a whole window: channel 0 at full scale, channel 1 alternating bit
    // patterns, channel 2 at zero except one full-scale entry.
    for (int k = 0; k < WINDOW_LEN; k++)
      send_store(sample_t'(AVG_MAX), (k % 2 == 0) ? 12'hAAA : 12'h555,
                 (k == 0) ? sample_t'(AVG_MAX) : '0);
    for (int c = 0; c < 4; c++) send_query(CHAN_W'(c));
    // Overwrite the oldest entry and check the ring wrapped onto it.
    send_store('0, 12'hFFF, 12'h001);
    send_query(2'd0);

    // Random part: mostly store runs with random content, queries sprinkled in,
    // with idle-free stretches and near-full-scale windows now and then.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i % 150 == 0) high_bias = ($urandom_range(0, 1) == 1);
      if (i % 150 == 40) high_bias = 1'b0;
      op = ($urandom_range(0, 9) < 6) ? OP_STORE : OP_QUERY;
      if (op == OP_STORE)
        send_store(pick_sample(high_bias), pick_sample(high_bias), pick_sample(high_bias));
      else
        send_query(CHAN_W'($urandom_range(0, 3)));
    end
    req_ch.valid <= 1'b0;

    // Drain: wait for every owed average, then keep watching in case the block
    // returns something extra.
    while (board.pending_averages.size() != 0) @(posedge clk);
    repeat (2 * (WINDOW_LEN + 3)) @(posedge clk);

    $display("Covered %0d sample frames and %0d channel queries; %0d averages compared.",
             board.stores, board.queries, board.checked);
    if (board.mismatches == 0 && board.pending_averages.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d averages never returned",
               board.mismatches, board.pending_averages.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/mba_pkg.sv
design/mba_req_if.sv
design/mba_rsp_if.sv
design/mba_ctrl.sv
design/mba_datapath.sv
design/multichannel_boxcar_averager_core.sv
tb/sv/tb_multichannel_boxcar_averager_core.sv
